// ===== rtl/wattu_pkg.sv =====
// ---------------------------------------------------------------------------
// wattu_pkg: shared types and constants for the tick-to-time converter
// Field widths, configuration register indexes, reset values and the
// handshake structs between the sequencer and the divider.
// ---------------------------------------------------------------------------
`default_nettype none

package wattu_pkg;

  // Default counter width
  localparam int TICK_BITS_DEF = 32;

  // Fixed field widths
  localparam int SEC_W  = 64;
  localparam int NS_W   = 32;
  localparam int FREQ_W = 32;
  localparam int WRAP_W = 32;
  localparam int NSPT_W = 30;
  localparam int CFG_W  = 32;
  localparam int CFG_IDX_W = 2;

  // Divider geometry: 64-bit dividend, one quotient bit per cycle
  localparam int DIVD_W    = 64;
  localparam int DIV_CNT_W = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICK_FREQ   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_VALUE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NS_PER_TICK = 2'd2;

  // Configuration reset values
  localparam logic [FREQ_W-1:0] TICK_FREQ_RST   = 32'd32768;
  localparam logic [WRAP_W-1:0] WRAP_VALUE_RST  = 32'hFFFF_FFFF;
  localparam logic [NSPT_W-1:0] NS_PER_TICK_RST = 30'd30517;

  // Result status codes
  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_NOT_STARTED = 1'b1;

  // Sequencer to divider
  typedef struct packed {
    logic start;
  } div_req_t;

  // Divider to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

// ===== rtl/wattu_div.sv =====
// ---------------------------------------------------------------------------
// wattu_div: iterative restoring divider
// Divides a 64-bit tick count by a 32-bit frequency, one quotient bit per
// cycle through a single 33-bit compare and subtract.
// ---------------------------------------------------------------------------
`default_nettype none

module wattu_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire wattu_pkg::div_req_t          req,
  input  wire logic [wattu_pkg::DIVD_W-1:0] dividend,
  input  wire logic [wattu_pkg::FREQ_W-1:0] divisor,
  output logic      [wattu_pkg::DIVD_W-1:0] quotient,
  output logic      [wattu_pkg::FREQ_W-1:0] remainder,
  output wattu_pkg::div_sts_t               sts
);
  import wattu_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIVD_W - 1);

  logic [FREQ_W-1:0]    rem_r;
  logic [DIVD_W-1:0]    quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [FREQ_W:0]      shifted;
  logic [FREQ_W:0]      diff;
  logic                 ge;
  logic [FREQ_W-1:0]    rem_nxt;

  // Shift in the next dividend bit and try one subtract
  always_comb begin
    shifted = {rem_r, quo_r[DIVD_W-1]};
    diff    = shifted - {1'b0, divisor};
    ge      = (shifted >= {1'b0, divisor});
    rem_nxt = ge ? diff[FREQ_W-1:0] : shifted[FREQ_W-1:0];
  end

  // Control: run for one step per quotient bit, pulse done at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIVD_W-2:0], ge};
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign sts.busy  = busy_r;
  assign sts.done  = done_r;

endmodule

`default_nettype wire

// ===== rtl/wrap_aware_tick_to_time_unit.sv =====
// ---------------------------------------------------------------------------
// wrap_aware_tick_to_time_unit: free-running tick counter to seconds + ns
// Sequencer, time state and output register around one divider.
// ---------------------------------------------------------------------------
// Each tick sample yields one time item (seconds, nanoseconds, status). A
// restart item, a sample taken before any restart, or a sample equal to the
// base tick goes straight from acceptance to the result load. Any other
// sample steps through the states for the wrap room, the tick delta and the
// divider launch, waits in the divide state for the 64 quotient steps of the
// bit-serial divider and its done flag, then passes the seconds accumulate
// and multiply, the base tick update and the result load. With a zero tick
// frequency the divider launch and divide states are skipped. One sample is
// in work at a time; the next is taken as soon as its result sits in the
// output register, even while that result waits to be taken. A result that
// is still waiting holds the following item in its load state until the
// output register frees up. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while idle, the
// block itself does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

module wrap_aware_tick_to_time_unit #(
  parameter int TICK_BITS = wattu_pkg::TICK_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [wattu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wattu_pkg::CFG_W-1:0]     cfg_data,
  // Sample input
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [((TICK_BITS+7)/8)*8-1:0]  in_tdata,  // [TICK_BITS-1:0] tick_sample
  input  wire logic                            in_tuser,  // [0] restart
  // Time output
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [wattu_pkg::SEC_W+wattu_pkg::NS_W-1:0] out_tdata, // [63:0] seconds,
                                                                 // [95:64] nanoseconds
  output logic                                 out_tuser  // [0] status
);
  import wattu_pkg::*;

  localparam int EXT_W = DIVD_W - TICK_BITS;

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ROOM   = 3'd1;
  localparam logic [2:0] ST_ADD    = 3'd2;
  localparam logic [2:0] ST_LAUNCH = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_ACC    = 3'd5;
  localparam logic [2:0] ST_BASE   = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;

  // Configuration registers
  logic [FREQ_W-1:0]    freq_r;
  logic [WRAP_W-1:0]    wrap_r;
  logic [NSPT_W-1:0]    nspt_r;

  // Time state
  logic [TICK_BITS-1:0] base_r;
  logic [SEC_W-1:0]     sec_r;
  logic [NS_W-1:0]      nanos_r;
  logic                 started_r;

  // Work registers
  logic [2:0]           state_r;
  logic [TICK_BITS-1:0] samp_r;
  logic                 gt_r;
  logic                 stat_r;
  logic [DIVD_W-1:0]    room_r;
  logic [DIVD_W-1:0]    add_r;
  logic [DIVD_W-1:0]    whole_r;
  logic [NS_W-1:0]      prod_r;

  // Output register
  logic                 out_valid_r;
  logic [SEC_W-1:0]     out_sec_r;
  logic [NS_W-1:0]      out_ns_r;
  logic                 out_stat_r;

  // Divider hookup
  div_req_t             div_req;
  div_sts_t             div_sts;
  logic [DIVD_W-1:0]    div_quo;
  logic [FREQ_W-1:0]    div_rem;

  // Combinational helpers
  logic [TICK_BITS-1:0] sample;
  logic                 in_acc;
  logic                 out_free;
  logic                 freq_zero;
  logic [DIVD_W-1:0]    secs;
  logic [DIVD_W-1:0]    rem64;
  logic [NSPT_W+NS_W-1:0] mul_full;
  logic [DIVD_W-1:0]    wrap_excess;

  assign sample    = in_tdata[TICK_BITS-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign freq_zero = (freq_r == '0);
  assign div_req.start = (state_r == ST_LAUNCH);

  // Split the delta; a zero frequency takes no whole seconds
  always_comb begin
    secs        = freq_zero ? '0 : div_quo;
    rem64       = freq_zero ? add_r : {{(DIVD_W-FREQ_W){1'b0}}, div_rem};
    mul_full    = rem64[NS_W-1:0] * nspt_r;
    wrap_excess = whole_r - room_r - 1'b1;
  end

  wattu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .dividend  (add_r),
    .divisor   (freq_r),
    .quotient  (div_quo),
    .remainder (div_rem),
    .sts       (div_sts)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= TICK_FREQ_RST;
      wrap_r <= WRAP_VALUE_RST;
      nspt_r <= NS_PER_TICK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICK_FREQ:   freq_r <= cfg_data[FREQ_W-1:0];
        REG_WRAP_VALUE:  wrap_r <= cfg_data[WRAP_W-1:0];
        REG_NS_PER_TICK: nspt_r <= cfg_data[NSPT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and time state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      base_r    <= '0;
      sec_r     <= '0;
      nanos_r   <= '0;
      started_r <= 1'b0;
      stat_r    <= STATUS_OK;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_tuser) begin
              base_r    <= sample;
              sec_r     <= '0;
              nanos_r   <= '0;
              started_r <= 1'b1;
              stat_r    <= STATUS_OK;
              state_r   <= ST_FIN;
            end else if (!started_r) begin
              stat_r  <= STATUS_NOT_STARTED;
              state_r <= ST_FIN;
            end else if (sample == base_r) begin
              stat_r  <= STATUS_OK;
              state_r <= ST_FIN;
            end else begin
              stat_r  <= STATUS_OK;
              state_r <= ST_ROOM;
            end
          end
        end
        ST_ROOM:   state_r <= ST_ADD;
        ST_ADD:    state_r <= freq_zero ? ST_ACC : ST_LAUNCH;
        ST_LAUNCH: state_r <= ST_DIV;
        ST_DIV: begin
          if (div_sts.done) begin
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          sec_r   <= sec_r + secs;
          state_r <= ST_BASE;
        end
        ST_BASE: begin
          // Advance base tick by whole-second ticks, wrapping past wrap_value
          if (whole_r <= room_r) begin
            base_r <= base_r + whole_r[TICK_BITS-1:0];
          end else begin
            base_r <= wrap_excess[TICK_BITS-1:0];
          end
          nanos_r <= prod_r;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Work datapath: sample capture, delta, whole ticks and product
  always_ff @(posedge clk) begin
    if (in_acc) begin
      samp_r <= sample;
      gt_r   <= (sample > base_r);
    end
    if (state_r == ST_ROOM) begin
      room_r <= {{(DIVD_W-WRAP_W){1'b0}}, wrap_r} - {{EXT_W{1'b0}}, base_r};
    end
    if (state_r == ST_ADD) begin
      if (gt_r) begin
        add_r <= {{EXT_W{1'b0}}, samp_r} - {{EXT_W{1'b0}}, base_r};
      end else begin
        add_r <= {{EXT_W{1'b0}}, samp_r} + room_r;
      end
    end
    if (state_r == ST_ACC) begin
      whole_r <= add_r - rem64;
      prod_r  <= mul_full[NS_W-1:0];
    end
  end

  // Output register: load on finish, drop on take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_FIN) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FIN) && out_free) begin
      out_stat_r <= stat_r;
      out_sec_r  <= (stat_r == STATUS_NOT_STARTED) ? '0 : sec_r;
      out_ns_r   <= (stat_r == STATUS_NOT_STARTED) ? '0 : nanos_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ns_r, out_sec_r};
  assign out_tuser  = out_stat_r;

  // A not-started item carries no time
  a_not_started_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == STATUS_NOT_STARTED)) |-> (out_tdata == '0))
    else $error("not-started item carries nonzero time");

  // A restart item always leaves the block started
  a_restart_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser) |=> started_r)
    else $error("restart did not set started");

  // The divider only runs while the sequencer waits on it
  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.busy |-> (state_r == ST_DIV))
    else $error("divider busy outside the divide state");

  // Short items go straight to the result load
  a_short_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser || !started_r)) |=> (state_r == ST_FIN))
    else $error("restart or not-started item took the long path");

endmodule

`default_nettype wire

// ===== test/tb_wrap_aware_tick_to_time_unit.sv =====
// ---------------------------------------------------------------------------
// tb_wrap_aware_tick_to_time_unit: tick sample to seconds/nanoseconds check
// Drives counter samples and restarts into the converter and predicts each
// time item with a local model of the base tick and second count. Results
// are checked in order against the queue of predicted items. The run covers
// samples taken before start, counter wraps, zero frequency, a base tick left
// past a lowered wrap value, and random configurations with random stalls
// on both sides, plus one long output hold that backs up the input.
// ---------------------------------------------------------------------------

module tb_wrap_aware_tick_to_time_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import wattu_pkg::*;

  localparam int          TICK_W       = 32;
  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int          LONG_HOLD    = 400;
  localparam int          TAIL_CYCLES  = 100;
  localparam logic [31:0] ONE_BILLION  = 32'd1000000000;

  typedef struct packed {
    logic [SEC_W-1:0] seconds;
    logic [NS_W-1:0]  nanos;
    logic             status;
  } time_item_t;

  // DUT signals
  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index  = REG_TICK_FREQ;
  logic [CFG_W-1:0]            cfg_data   = '0;
  logic                        in_tvalid  = 1'b0;
  logic                        in_tready;
  logic [TICK_W-1:0]           in_tdata   = '0;  // [31:0] tick_sample
  logic                        in_tuser   = 1'b0; // [0] restart
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [SEC_W+NS_W-1:0]       out_tdata;  // [63:0] seconds, [95:64] nanoseconds
  logic                        out_tuser;  // [0] status

  // Local copy of the converter configuration and time state
  logic [31:0]     freq_reg = TICK_FREQ_RST;
  logic [31:0]     wrap_reg = WRAP_VALUE_RST;
  logic [29:0]     nspt_reg = NS_PER_TICK_RST;
  logic [31:0]     anchor_tick   = '0;
  logic [63:0]     elapsed_sec   = '0;
  logic [31:0]     elapsed_ns    = '0;
  logic            clock_running = 1'b0;

  time_item_t      pending_times[$];
  int              errors       = 0;
  bit              src_idle     = 1'b1;
  logic            snk_idle     = 1'b1;
  int              hold_reqs    = 0;

  wrap_aware_tick_to_time_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the local time state by one sample and return the time item
  function automatic time_item_t predict_time(input logic [31:0] sample,
                                              input logic restart);
    time_item_t  item;
    logic [63:0] add;
    logic [63:0] secs;
    logic [63:0] whole;
    logic [63:0] room;
    logic [63:0] prod;
    logic [63:0] past;
    item = '{seconds: '0, nanos: '0, status: STATUS_NOT_STARTED};
    if (restart) begin
      anchor_tick   = sample;
      elapsed_sec   = '0;
      elapsed_ns    = '0;
      clock_running = 1'b1;
    end else if (clock_running && sample != anchor_tick) begin
      // Count ticks since the anchor, across a wrap when below it
      if (sample > anchor_tick)
        add = {32'd0, sample} - {32'd0, anchor_tick};
      else
        add = {32'd0, sample} + ({32'd0, wrap_reg} - {32'd0, anchor_tick});
      secs  = '0;
      whole = '0;
      if (freq_reg != '0) begin
        secs  = add / {32'd0, freq_reg};
        whole = secs * {32'd0, freq_reg};
      end
      elapsed_sec = elapsed_sec + secs;
      prod        = (add - whole) * {34'd0, nspt_reg};
      elapsed_ns  = prod[31:0];
      // Move the anchor onto the last whole second, wrapping past wrap_reg
      room = {32'd0, wrap_reg} - {32'd0, anchor_tick};
      if (whole <= room) begin
        anchor_tick = anchor_tick + whole[31:0];
      end else begin
        past        = whole - room - 64'd1;
        anchor_tick = past[31:0];
      end
    end
    if (clock_running)
      item = '{seconds: elapsed_sec, nanos: elapsed_ns, status: STATUS_OK};
    return item;
  endfunction

  // Offer one item, hold it until taken, then record its predicted time
  task automatic send_item(input logic [31:0] sample, input logic restart);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    pending_times.push_back(predict_time(sample, restart));
  endtask

  // Stop offering and wait for every predicted item to come back
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_times.size() != 0);
  endtask

  // Drain, then write all three registers on consecutive cycles
  task automatic reconfigure(input logic [31:0] freq, input logic [31:0] wrap,
                             input logic [29:0] nspt);
    wait_results_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_TICK_FREQ;
    cfg_data  <= freq;
    @(posedge clk);
    cfg_index <= REG_WRAP_VALUE;
    cfg_data  <= wrap;
    @(posedge clk);
    cfg_index <= REG_NS_PER_TICK;
    cfg_data  <= {2'b00, nspt};
    @(posedge clk);
    cfg_we    <= 1'b0;
    freq_reg = freq;
    wrap_reg = wrap;
    nspt_reg = nspt;
  endtask

  // Random walk of the counter: mostly forward steps, some repeats,
  // restarts and out-of-order noise
  task automatic run_random_phase(input logic [31:0] freq, input logic [31:0] wrap,
                                  input logic [29:0] nspt, input int n_items);
    logic [63:0] cur;
    logic [63:0] span;
    logic [63:0] step;
    logic        rst_bit;
    int          pick;
    reconfigure(freq, wrap, nspt);
    cur = {$urandom, $urandom} % ({32'd0, wrap} + 64'd1);
    send_item(cur[31:0], 1'b1);
    for (int i = 0; i < n_items; i++) begin
      pick    = $urandom_range(0, 99);
      rst_bit = 1'b0;
      if (pick < 6) begin
        cur     = {$urandom, $urandom} % ({32'd0, wrap} + 64'd1);
        rst_bit = 1'b1;
      end else if (pick < 14) begin
        // repeat the last sample
      end else if (pick < 20) begin
        cur = {32'd0, $urandom};
      end else begin
        case ($urandom_range(0, 2))
          0:       span = 64'd64;
          1:       span = (freq == '0) ? 64'd4096 : {32'd0, freq} * 64'd4;
          default: span = 64'h1_0000_0000;
        endcase
        step = {$urandom, $urandom} % span + 64'd1;
        cur  = (cur + step) % ({32'd0, wrap} + 64'd1);
      end
      send_item(cur[31:0], rst_bit);
    end
  endtask

  // Samples before any restart report not started
  task automatic test_before_restart();
    send_item(32'd0, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item($urandom, 1'b0);
  endtask

  // Whole seconds, equal samples and counter wraps at reset settings
  task automatic test_default_time_flow();
    reconfigure(TICK_FREQ_RST, WRAP_VALUE_RST, NS_PER_TICK_RST);
    send_item(32'd0, 1'b1);
    send_item(32'd32768, 1'b0);
    send_item(32'd32768, 1'b0);
    send_item(32'd49152, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'hFFFF_FFF0, 1'b1);
    send_item(32'd5, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    send_item(32'd0, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
  endtask

  // No whole seconds taken; nanosecond product overflows 32 bits
  task automatic test_zero_freq();
    reconfigure(32'd0, WRAP_VALUE_RST, ONE_BILLION[29:0]);
    send_item(32'd100, 1'b1);
    send_item(32'd200, 1'b0);
    send_item(32'd50, 1'b0);
  endtask

  // Lower the wrap value below a live anchor tick
  task automatic test_base_past_wrap();
    reconfigure(32'd10, WRAP_VALUE_RST, 30'd100);
    send_item(32'hFFFF_FFF0, 1'b1);
    reconfigure(32'd10, 32'd100, 30'd100);
    send_item(32'd50, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    reconfigure(32'hFFFF_FFFF, 32'd1, 30'd0);
    send_item(32'd1, 1'b1);
    send_item(32'd0, 1'b0);
  endtask

  // Hold the output for a long stretch while items keep coming, then pause
  task automatic test_output_backpressure();
    reconfigure(TICK_FREQ_RST, WRAP_VALUE_RST, NS_PER_TICK_RST);
    src_idle = 1'b0;
    snk_idle <= 1'b0;
    send_item(32'd1000, 1'b1);
    hold_reqs <= hold_reqs + 1;
    for (int i = 0; i < 24; i++)
      send_item(32'd1000 + 32'(i / 2) * 32'd20000, 1'b0);
    wait_results_drained();
    for (int i = 0; i < 4; i++)
      send_item($urandom, 1'b0);
  endtask

  // Walk through several settings, extremes included, varying the idling
  task automatic test_random_settings();
    logic [31:0] freq;
    for (int p = 0; p < 7; p++) begin
      src_idle = (p % 3 != 2);
      snk_idle <= (p % 3 != 1);
      case (p)
        0: run_random_phase(TICK_FREQ_RST, WRAP_VALUE_RST, NS_PER_TICK_RST, 80);
        1: run_random_phase(32'd1, 32'hFFFF_FFFF, ONE_BILLION[29:0], 80);
        2: run_random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, ONE_BILLION[29:0], 80);
        3: run_random_phase(32'd1000, 32'd9999, 30'd1000000, 80);
        4: run_random_phase(32'd7, 32'd1, 30'd0, 80);
        5: begin
          freq = $urandom_range(1, 1 << 20);
          run_random_phase(freq, $urandom_range(1000, 32'hFFFF_FFFF),
                           30'(ONE_BILLION / freq), 80);
        end
        default: run_random_phase($urandom_range(1, 32'hFFFF_FFFF), $urandom,
                                  30'($urandom_range(0, ONE_BILLION)), 80);
      endcase
    end
  endtask

  // Closing stretch with both sides streaming freely
  task automatic test_final_stream();
    src_idle = 1'b0;
    snk_idle <= 1'b0;
    run_random_phase(32'd50000, 32'hFFFF_FFFF, 30'd20000, 50);
  endtask

  // Output side: random stall bursts and the requested long hold
  initial begin : sink_ctl
    int holds_served;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_served) begin
        holds_served++;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
      end else if (snk_idle && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each taken item with the oldest prediction
  always @(posedge clk) begin : result_check
    time_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_times.size() == 0) begin
        $error("unexpected item: seconds %0d nanoseconds %0d status %0d",
               out_tdata[SEC_W-1:0], out_tdata[SEC_W+NS_W-1:SEC_W], out_tuser);
        errors++;
      end else begin
        want = pending_times.pop_front();
        if (out_tdata[SEC_W-1:0] !== want.seconds) begin
          $error("seconds: expected %0d, actual %0d", want.seconds,
                 out_tdata[SEC_W-1:0]);
          errors++;
        end
        if (out_tdata[SEC_W+NS_W-1:SEC_W] !== want.nanos) begin
          $error("nanoseconds: expected %0d, actual %0d", want.nanos,
                 out_tdata[SEC_W+NS_W-1:SEC_W]);
          errors++;
        end
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tuser);
          errors++;
        end
      end
    end
  end

  // Cycle budget for the whole run
  initial begin : watchdog
    int unsigned n;
    for (n = 0; n < LIMIT_CYCLES; n++) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_before_restart();
    test_default_time_flow();
    test_zero_freq();
    test_base_past_wrap();
    test_output_backpressure();
    test_random_settings();
    test_final_stream();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
